// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files. They expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/brhp_pkg.sv -----
`default_nettype none

package brhp_pkg;

    // Field width of sizes, offsets and lengths on the ports
    localparam int FIELD_W = 63;
    // Default width of the accumulated numbers
    localparam int NUM_W_DEFAULT = 63;

    // Status codes
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_VALID   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // Characters
    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Length of the "bytes=" prefix
    localparam logic [2:0] PREFIX_LEN = 3'd6;

    typedef struct packed {
        logic [7:0]         char_code;
        logic               header_empty;
        logic               last_char;
        logic [FIELD_W-1:0] total_size;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] range_offset;
        logic [FIELD_W-1:0] range_length;
    } t_out_word;

    // Header summary handed from the parser to the resolver
    typedef struct packed {
        logic empty;
        logic bad;
        logic seen_dash;
        logic first_present;
        logic second_present;
    } t_snap_flags;

    // Expected character at each prefix position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h62; // b
            3'd1:    ch = 8'h79; // y
            3'd2:    ch = 8'h74; // t
            3'd3:    ch = 8'h65; // e
            3'd4:    ch = 8'h73; // s
            3'd5:    ch = 8'h3D; // =
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- sv/brhp_parser.sv -----
`default_nettype none
`include "assert_macros.svh"

module brhp_parser #(
    parameter int NUMBER_WIDTH = brhp_pkg::NUM_W_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire brhp_pkg::t_in_word            i_word,
    output logic                               o_ready,
    output logic                               o_snap_valid,
    output brhp_pkg::t_snap_flags              o_snap_flags,
    output logic [NUMBER_WIDTH-1:0]            o_snap_first,
    output logic [NUMBER_WIDTH-1:0]            o_snap_second,
    output logic [brhp_pkg::FIELD_W-1:0]       o_snap_size,
    input  wire logic                          i_snap_ready
);
    import brhp_pkg::*;

    localparam int W = NUMBER_WIDTH;

    logic [2:0]         r_prefix_pos, n_prefix_pos;
    logic               r_seen_dash, n_seen_dash;
    logic               r_bad, n_bad;
    logic [W-1:0]       r_first, n_first;
    logic               r_first_pres, n_first_pres;
    logic [W-1:0]       r_second, n_second;
    logic               r_second_pres, n_second_pres;
    logic [FIELD_W-1:0] r_size, n_size;

    logic               r_snap_valid;
    t_snap_flags        r_snap_flags, n_snap_flags;
    logic [W-1:0]       r_snap_first;
    logic [W-1:0]       r_snap_second;
    logic [FIELD_W-1:0] r_snap_size;

    logic               ends_header;
    logic               take;
    logic               is_dash;
    logic               is_digit;
    logic [3:0]         digit;
    logic [W-1:0]       acc_sel;
    logic [W+3:0]       acc_next;
    logic               acc_ovf;

    // Consume a word unless it ends the header and the summary slot is full and not being drained
    assign ends_header = i_word.last_char | i_word.header_empty;
    assign o_ready     = !ends_header || !r_snap_valid || i_snap_ready;
    assign take        = i_valid && o_ready;

    // Classify the character and form acc * 10 + digit with overflow bits
    assign is_dash  = (i_word.char_code == CHAR_DASH);
    assign is_digit = (i_word.char_code >= CHAR_ZERO) && (i_word.char_code <= CHAR_NINE);
    assign digit    = 4'(i_word.char_code - CHAR_ZERO);
    assign acc_sel  = r_seen_dash ? r_second : r_first;
    assign acc_next = (W+4)'({acc_sel, 3'b000}) + (W+4)'({acc_sel, 1'b0}) + (W+4)'(digit);
    assign acc_ovf  = |acc_next[W+3:W];

    // Parse state after this character
    always_comb begin
        n_prefix_pos  = r_prefix_pos;
        n_seen_dash   = r_seen_dash;
        n_bad         = r_bad;
        n_first       = r_first;
        n_first_pres  = r_first_pres;
        n_second      = r_second;
        n_second_pres = r_second_pres;
        n_size        = (r_prefix_pos == 3'd0) ? i_word.total_size : r_size;
        if (r_prefix_pos < PREFIX_LEN) begin
            if (i_word.char_code != prefix_char(r_prefix_pos)) begin
                n_bad = 1'b1;
            end
            n_prefix_pos = 3'(r_prefix_pos + 3'd1);
        end else if (!r_bad) begin
            if (is_dash) begin
                if (r_seen_dash) begin
                    n_bad = 1'b1;
                end
                n_seen_dash = 1'b1;
            end else if (is_digit) begin
                if (acc_ovf) begin
                    n_bad = 1'b1;
                end else if (r_seen_dash) begin
                    n_second      = acc_next[W-1:0];
                    n_second_pres = 1'b1;
                end else begin
                    n_first      = acc_next[W-1:0];
                    n_first_pres = 1'b1;
                end
            end else begin
                n_bad = 1'b1;
            end
        end
    end

    // Summary flags for a header that ends here
    always_comb begin
        n_snap_flags = '0;
        if (i_word.header_empty) begin
            n_snap_flags.empty = 1'b1;
        end else begin
            n_snap_flags.bad            = n_bad || (n_prefix_pos < PREFIX_LEN);
            n_snap_flags.seen_dash      = n_seen_dash;
            n_snap_flags.first_present  = n_first_pres;
            n_snap_flags.second_present = n_second_pres;
        end
    end

    // Advance parse state; clear it when a header ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_pos  <= '0;
            r_seen_dash   <= 1'b0;
            r_bad         <= 1'b0;
            r_first       <= '0;
            r_first_pres  <= 1'b0;
            r_second      <= '0;
            r_second_pres <= 1'b0;
            r_size        <= '0;
            r_snap_valid  <= 1'b0;
        end else begin
            if (take) begin
                if (ends_header) begin
                    r_prefix_pos  <= '0;
                    r_seen_dash   <= 1'b0;
                    r_bad         <= 1'b0;
                    r_first       <= '0;
                    r_first_pres  <= 1'b0;
                    r_second      <= '0;
                    r_second_pres <= 1'b0;
                end else begin
                    r_prefix_pos  <= n_prefix_pos;
                    r_seen_dash   <= n_seen_dash;
                    r_bad         <= n_bad;
                    r_first       <= n_first;
                    r_first_pres  <= n_first_pres;
                    r_second      <= n_second;
                    r_second_pres <= n_second_pres;
                end
                if (!i_word.header_empty) begin
                    r_size <= n_size;
                end
            end
            if (take && ends_header) begin
                r_snap_valid <= 1'b1;
            end else if (i_snap_ready) begin
                r_snap_valid <= 1'b0;
            end
        end
    end

    // Hold the summary of the finished header
    always_ff @(posedge i_clk) begin
        if (take && ends_header) begin
            r_snap_flags  <= n_snap_flags;
            r_snap_first  <= n_first;
            r_snap_second <= n_second;
            r_snap_size   <= n_size;
        end
    end

    assign o_snap_valid  = r_snap_valid;
    assign o_snap_flags  = r_snap_flags;
    assign o_snap_first  = r_snap_first;
    assign o_snap_second = r_snap_second;
    assign o_snap_size   = r_snap_size;

    `ASSERT_IMP(a_prefix_sat, 1'b1, r_prefix_pos <= PREFIX_LEN, "prefix counter ran past six")
    `ASSERT_NXT(a_clear_after_end, take && ends_header,
        (r_prefix_pos == 3'd0) && !r_seen_dash && !r_bad, "parse state not cleared at header end")

endmodule

`default_nettype wire

// ----- sv/brhp_resolver.sv -----
`default_nettype none
`include "assert_macros.svh"

module brhp_resolver #(
    parameter int NUMBER_WIDTH = brhp_pkg::NUM_W_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_snap_valid,
    input  wire brhp_pkg::t_snap_flags         i_snap_flags,
    input  wire logic [NUMBER_WIDTH-1:0]       i_snap_first,
    input  wire logic [NUMBER_WIDTH-1:0]       i_snap_second,
    input  wire logic [brhp_pkg::FIELD_W-1:0]  i_snap_size,
    output logic                               o_snap_ready,
    output logic                               o_out_valid,
    output brhp_pkg::t_out_word                o_out_data,
    input  wire logic                          i_out_ready
);
    import brhp_pkg::*;

    logic               r_out_valid;
    t_out_word          r_out, n_out;

    logic [FIELD_W-1:0] first_v;
    logic [FIELD_W-1:0] second_v;
    logic [FIELD_W-1:0] size_v;
    logic [FIELD_W-1:0] size_minus_first;
    logic [FIELD_W-1:0] second_span;
    logic [FIELD_W-1:0] size_minus_second;
    logic               second_below_size;
    logic               take;

    assign first_v  = FIELD_W'(i_snap_first);
    assign second_v = FIELD_W'(i_snap_second);
    assign size_v   = i_snap_size;

    // Candidate offsets and lengths, formed side by side
    assign size_minus_first  = size_v - first_v;
    assign second_span       = FIELD_W'(second_v - first_v + FIELD_W'(1));
    assign size_minus_second = size_v - second_v;
    assign second_below_size = second_v < size_v;

    // Resolve the header against the file size
    always_comb begin
        n_out = '{status: ST_INVALID, range_offset: '0, range_length: '0};
        priority if (i_snap_flags.empty) begin
            n_out.status = ST_NONE;
        end else if (i_snap_flags.bad || (size_v == '0) || !i_snap_flags.seen_dash) begin
            n_out.status = ST_INVALID;
        end else if (!i_snap_flags.first_present) begin
            // Suffix form: last N bytes, clamped to the file
            if (i_snap_flags.second_present && (second_v != '0)) begin
                n_out.status = ST_VALID;
                if (second_below_size) begin
                    n_out.range_offset = size_minus_second;
                    n_out.range_length = second_v;
                end else begin
                    n_out.range_length = size_v;
                end
            end
        end else if ((first_v < size_v)
                     && !(i_snap_flags.second_present && (second_v < first_v))) begin
            // Start-end form: a missing or too large end clamps to the file end
            n_out.status       = ST_VALID;
            n_out.range_offset = first_v;
            n_out.range_length = (i_snap_flags.second_present && second_below_size)
                                 ? second_span : size_minus_first;
        end else begin
            n_out.status = ST_INVALID;
        end
    end

    assign o_snap_ready = !r_out_valid || i_out_ready;
    assign take         = i_snap_valid && o_snap_ready;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_IMP(a_len_nonzero, r_out_valid && (r_out.status == ST_VALID),
        r_out.range_length != '0, "valid range with zero length")
    `ASSERT_IMP(a_zero_unless_valid, r_out_valid && (r_out.status != ST_VALID),
        (r_out.range_offset == '0) && (r_out.range_length == '0), "nonzero range on non-valid")

endmodule

`default_nettype wire

// ----- sv/byte_range_header_parser.sv -----
// Byte-range header parser, one header character per word.
// Throughput: one word per cycle, with or without result, stalled only by the result side.
// Path: the word that ends a header passes the input register, the parse and summary
// register, and the resolve and result register before its result is presented.
// Reset: i_rst_n synchronous active low; clears all valid flags, parse state and size.
`default_nettype none

module byte_range_header_parser #(
    parameter int NUMBER_WIDTH = brhp_pkg::NUM_W_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire brhp_pkg::t_in_word  i_in_data,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output brhp_pkg::t_out_word      o_out_data,
    input  wire logic                i_out_ready
);
    import brhp_pkg::*;

    logic               r_in_valid;
    t_in_word           r_in;
    logic               parse_ready;

    logic               snap_valid;
    logic               snap_ready;
    t_snap_flags        snap_flags;
    logic [NUMBER_WIDTH-1:0] snap_first;
    logic [NUMBER_WIDTH-1:0] snap_second;
    logic [FIELD_W-1:0] snap_size;

    // Input register: take a word when empty or when the parser drains it
    assign o_in_ready = !r_in_valid || parse_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    brhp_parser #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_word        (r_in),
        .o_ready       (parse_ready),
        .o_snap_valid  (snap_valid),
        .o_snap_flags  (snap_flags),
        .o_snap_first  (snap_first),
        .o_snap_second (snap_second),
        .o_snap_size   (snap_size),
        .i_snap_ready  (snap_ready)
    );

    brhp_resolver #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_resolver (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_snap_valid  (snap_valid),
        .i_snap_flags  (snap_flags),
        .i_snap_first  (snap_first),
        .i_snap_second (snap_second),
        .i_snap_size   (snap_size),
        .o_snap_ready  (snap_ready),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_ready   (i_out_ready)
    );

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import brhp_pkg::*;

    localparam int          NUM_W          = NUM_W_DEFAULT;
    localparam logic [63:0] NUM_MAX        = (64'd1 << NUM_W) - 64'd1;
    localparam logic [62:0] SIZE_MAX       = {FIELD_W{1'b1}};
    localparam logic [47:0] PREFIX_BYTES   = "bytes=";
    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          RANDOM_WORDS   = 1500;
    localparam int          CALM_AFTER     = 1300;
    localparam int          HOLD_AT        = 400;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          DIR_ROWS       = 12;

    typedef struct {
        string       text;
        bit          end_empty;
        logic [62:0] size;
        bit          typed;
        logic [1:0]  status;
        logic [62:0] offset;
        logic [62:0] length;
    } t_dir_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_data;

    byte_range_header_parser uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_ready (out_ready)
    );

    always #4 clk = ~clk;

    // Range parser state, mirrored word by word
    logic [2:0]  pos_in_prefix = '0;
    bit          dash_found    = 1'b0;
    bit          header_bad    = 1'b0;
    logic [63:0] start_num     = '0;
    bit          start_seen    = 1'b0;
    logic [63:0] stop_num      = '0;
    bit          stop_seen     = 1'b0;
    logic [62:0] latched_size  = '0;

    t_out_word   pending_ranges[$];
    int          words_taken   = 0;
    int          err_count     = 0;
    int          idle_cycles   = 0;
    bit          calm          = 1'b0;
    bit          sender_quiet  = 1'b0;
    bit          hold_req      = 1'b0;
    t_dir_row    dir_rows [DIR_ROWS];

    task automatic clear_header();
        pos_in_prefix = '0;
        dash_found    = 1'b0;
        header_bad    = 1'b0;
        start_num     = '0;
        start_seen    = 1'b0;
        stop_num      = '0;
        stop_seen     = 1'b0;
    endtask

    // Append one decimal digit, or mark the header bad on overflow
    task automatic add_digit(inout logic [63:0] acc, inout bit seen, input logic [63:0] d);
        if (acc > (NUM_MAX - d) / 64'd10) begin
            header_bad = 1'b1;
        end else begin
            acc  = acc * 64'd10 + d;
            seen = 1'b1;
        end
    endtask

    task automatic parse_range_word(input t_in_word w, output bit produced,
                                    output t_out_word res);
        logic [63:0] size;
        logic [63:0] take;
        logic [63:0] stop_pos;
        logic [63:0] span;
        produced = 1'b0;
        res      = '0;
        if (w.header_empty) begin
            // Drop any partial header
            clear_header();
            res.status = ST_NONE;
            produced   = 1'b1;
        end else begin
            if (pos_in_prefix == 3'd0) begin
                latched_size = w.total_size;
            end
            // Consume the character
            if (pos_in_prefix < PREFIX_LEN) begin
                if (w.char_code != PREFIX_BYTES[8 * (5 - int'(pos_in_prefix)) +: 8]) begin
                    header_bad = 1'b1;
                end
                pos_in_prefix = pos_in_prefix + 3'd1;
            end else if (!header_bad) begin
                if (w.char_code == CHAR_DASH) begin
                    if (dash_found) begin
                        header_bad = 1'b1;
                    end
                    dash_found = 1'b1;
                end else if (w.char_code >= CHAR_ZERO && w.char_code <= CHAR_NINE) begin
                    if (dash_found) begin
                        add_digit(stop_num, stop_seen, 64'(w.char_code - CHAR_ZERO));
                    end else begin
                        add_digit(start_num, start_seen, 64'(w.char_code - CHAR_ZERO));
                    end
                end else begin
                    header_bad = 1'b1;
                end
            end
            // Resolve the range on the closing character
            if (w.last_char) begin
                size       = {1'b0, latched_size};
                res.status = ST_INVALID;
                if (!(header_bad || pos_in_prefix < PREFIX_LEN
                      || size == 64'd0 || !dash_found)) begin
                    if (!start_seen) begin
                        if (stop_seen && stop_num != 64'd0) begin
                            take               = (stop_num < size) ? stop_num : size;
                            span               = size - take;
                            res.status         = ST_VALID;
                            res.range_length   = take[62:0];
                            res.range_offset   = span[62:0];
                        end
                    end else if (start_num < size && !(stop_seen && stop_num < start_num)) begin
                        stop_pos         = (stop_seen && stop_num < size) ? stop_num
                                                                          : size - 64'd1;
                        span             = stop_pos - start_num + 64'd1;
                        res.status       = ST_VALID;
                        res.range_offset = start_num[62:0];
                        res.range_length = span[62:0];
                    end
                end
                clear_header();
                produced = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < 40) begin
            $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
        end
        err_count++;
    endtask

    function automatic logic [62:0] rand_bits63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    function automatic logic [62:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_MAX;
            2, 3:    return rand_bits63();
            default: return 63'($urandom_range(1, 2000));
        endcase
    endfunction

    // Decimal text for a number, biased toward the file end and the overflow edge
    function automatic string make_number(input logic [62:0] size);
        logic [63:0] v;
        string       s;
        case ($urandom_range(0, 9))
            0, 1, 2: v = 64'($urandom_range(0, 2500));
            3:       v = {1'b0, size} + 64'($urandom_range(0, 4)) - 64'd2;
            4:       v = NUM_MAX - 64'd2 + 64'($urandom_range(0, 4));
            5:       v = {$urandom, $urandom};
            6:       v = {1'b0, size} >> $urandom_range(0, 62);
            default: v = 64'($urandom_range(0, 20));
        endcase
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 7) == 0) begin
            s = {"0", s};
        end
        if ($urandom_range(0, 15) == 0) begin
            s = {s, "7"};
        end
        return s;
    endfunction

    // Offer one word, wait for it to be taken, then predict its result
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        bit        produced;
        t_out_word predicted;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        words_taken++;
        if (words_taken == HOLD_AT) begin
            hold_req = 1'b1;
        end
        parse_range_word(w, produced, predicted);
        if (produced) begin
            pending_ranges.insert(pending_ranges.size(), typed ? want : predicted);
        end
        if (!calm && !sender_quiet && !hold_req && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_header(input string text, input bit end_empty, input logic [62:0] size,
                               input bit typed, input t_out_word want);
        t_in_word w;
        int       n;
        n = text.len();
        for (int i = 0; i < n; i++) begin
            w.char_code    = text[i];
            w.header_empty = 1'b0;
            w.last_char    = (i == n - 1) && !end_empty;
            w.total_size   = (i == 0) ? size : rand_bits63();
            send_word(w, typed && w.last_char, want);
        end
        if (end_empty) begin
            w.char_code    = 8'($urandom_range(0, 255));
            w.header_empty = 1'b1;
            w.last_char    = 1'($urandom_range(0, 1));
            w.total_size   = (n == 0) ? size : rand_bits63();
            send_word(w, typed, want);
        end
    endtask

    task automatic send_random_header();
        string       text;
        string       mark;
        logic [62:0] size;
        int          kind;
        int          n;
        int          p;
        bit          drop;
        t_in_word    w;
        t_out_word   none;
        none = '0;
        drop = 1'b0;
        size = pick_size();
        case ($urandom_range(0, 2))
            0:       text = {"bytes=", make_number(size), "-", make_number(size)};
            1:       text = {"bytes=", make_number(size), "-"};
            default: text = {"bytes=-", make_number(size)};
        endcase
        kind = $urandom_range(0, 19);
        if (kind < 13) begin
            send_header(text, 1'b0, size, 1'b0, none);
        end else if (kind < 17) begin
            // Break a well-formed header at one spot
            n    = text.len();
            p    = $urandom_range(0, n - 1);
            mark = $urandom_range(0, 1) ? "," : "-";
            case ($urandom_range(0, 3))
                0:       text.putc(p, 8'($urandom_range(1, 255)));
                1:       text = {text.substr(0, p), mark, text.substr(p + 1, n - 1)};
                2:       text = text.substr(0, p);
                default: begin
                    text = text.substr(0, p);
                    drop = 1'b1;
                end
            endcase
            send_header(text, drop, size, 1'b0, none);
        end else if (kind < 19) begin
            // Raw bytes of any value
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                w.char_code    = 8'($urandom_range(0, 255));
                w.header_empty = 1'b0;
                w.last_char    = (i == n - 1);
                w.total_size   = (i == 0) ? size : rand_bits63();
                send_word(w, 1'b0, none);
            end
        end else begin
            send_header("", 1'b1, size, 1'b0, none);
        end
    endtask

    // Stimulus: reset, directed table, random headers, drain
    initial begin : stimulus
        t_out_word want;
        int        random_start;
        dir_rows[0]  = '{"", 1'b1, 63'd0, 1'b1, ST_NONE, 63'd0, 63'd0};
        dir_rows[1]  = '{"\377", 1'b0, SIZE_MAX, 1'b1, ST_INVALID, 63'd0, 63'd0};
        dir_rows[2]  = '{"bytes=0-", 1'b0, 63'd0, 1'b1, ST_INVALID, 63'd0, 63'd0};
        dir_rows[3]  = '{"bytes=-5", 1'b0, 63'd3, 1'b0, ST_NONE, 63'd0, 63'd0};
        dir_rows[4]  = '{"bytes=-0", 1'b0, 63'd10, 1'b1, ST_INVALID, 63'd0, 63'd0};
        dir_rows[5]  = '{"bytes=4-2", 1'b0, 63'd10, 1'b1, ST_INVALID, 63'd0, 63'd0};
        dir_rows[6]  = '{"bytes=3-", 1'b0, SIZE_MAX, 1'b0, ST_NONE, 63'd0, 63'd0};
        dir_rows[7]  = '{"bytes=5-99", 1'b0, 63'd10, 1'b0, ST_NONE, 63'd0, 63'd0};
        dir_rows[8]  = '{"bytes=9223372036854775808-", 1'b0, SIZE_MAX, 1'b1, ST_INVALID,
                         63'd0, 63'd0};
        dir_rows[9]  = '{"byt", 1'b1, 63'd7, 1'b1, ST_NONE, 63'd0, 63'd0};
        dir_rows[10] = '{"bytes=1,2", 1'b0, 63'd10, 1'b1, ST_INVALID, 63'd0, 63'd0};
        dir_rows[11] = '{"bytes=0-0", 1'b0, 63'd1, 1'b1, ST_VALID, 63'd0, 63'd1};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            want.status       = dir_rows[r].status;
            want.range_offset = dir_rows[r].offset;
            want.range_length = dir_rows[r].length;
            send_header(dir_rows[r].text, dir_rows[r].end_empty, dir_rows[r].size,
                        dir_rows[r].typed, want);
        end

        // Random headers, with no idling near the end
        random_start = words_taken;
        while (words_taken - random_start < RANDOM_WORDS) begin
            calm         = (words_taken - random_start >= CALM_AFTER);
            sender_quiet = ($urandom_range(0, 3) == 0);
            send_random_header();
        end
        in_valid <= 1'b0;

        while (pending_ranges.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, quiet stretches
    initial begin : receiver
        int pick;
        @(posedge clk);
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            @(posedge clk);
            pick = $urandom_range(0, 9);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
                hold_req = 1'b0;
            end else if (!calm && pick < 3) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_ready <= 1'b1;
            end else if (pick == 9) begin
                out_ready <= 1'b1;
                repeat (40) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Check each result word against the oldest expected range
    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_ranges.size() == 0) begin
                report_mismatch("unexpected result status", 64'(out_data.status), 64'd0);
            end else begin
                want = pending_ranges.pop_front();
                if (out_data.status !== want.status) begin
                    report_mismatch("status", 64'(out_data.status), 64'(want.status));
                end
                if (out_data.range_offset !== want.range_offset) begin
                    report_mismatch("range_offset", 64'(out_data.range_offset),
                                    64'(want.range_offset));
                end
                if (out_data.range_length !== want.range_length) begin
                    report_mismatch("range_length", 64'(out_data.range_length),
                                    64'(want.range_length));
                end
            end
        end
    end

    // Stop the run when no word moves for too long
    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// ----- byte_range_header_parser.f -----
+incdir+sv
sv/brhp_pkg.sv
sv/brhp_parser.sv
sv/brhp_resolver.sv
sv/byte_range_header_parser.sv
verif/tb.sv
